[rtl/core/ultrasonic_ping_ranger_assert.svh]
// ----------------------------------------------------------------------------
// Ultrasonic ping ranger assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_PING_RANGER_ASSERT_SVH
`define ULTRASONIC_PING_RANGER_ASSERT_SVH
`ifndef ASSERT_OFF
`define UPR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ultrasonic_ping_ranger: assertion failed");
`define UPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ultrasonic_ping_ranger: assertion failed");
`else
`define UPR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define UPR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/upr_pkg.sv]
// ----------------------------------------------------------------------------
// Ultrasonic ping ranger package
// Phase type, status codes, register indexes, reset values and mm conversion constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package upr_pkg;

  typedef enum logic [1:0] {
    PH_HOLDOFF  = 2'd0,
    PH_TRIGGER  = 2'd1,
    PH_WAITRISE = 2'd2,
    PH_ECHO     = 2'd3
  } phase_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NORESP = 2'd1;
  localparam logic [1:0] ST_EPE    = 2'd2;
  localparam logic [1:0] ST_FAR    = 2'd3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MM_PER_MS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIMIT = 3'd5;

  localparam logic [15:0] RST_HOLDOFF      = 16'd200;
  localparam logic [7:0]  RST_TRIGGER      = 8'd5;
  localparam logic [15:0] RST_RISE_TIMEOUT = 16'd850;
  localparam logic [15:0] RST_ECHO_MAX     = 16'd18500;
  localparam logic [9:0]  RST_MM_PER_MS    = 10'd174;
  localparam logic [15:0] RST_RANGE_LIMIT  = 16'd3000;

  localparam logic [10:0] MM_DIV = 11'd1000;

  // floor(p / 1000) = (p * MM_RECIP) >> MM_RECIP_SHIFT, exact for p < 2^26
  localparam logic [26:0] MM_RECIP       = 27'd68719477;
  localparam int          MM_RECIP_SHIFT = 36;

endpackage

[rtl/core/ultrasonic_ping_ranger.sv]
// ----------------------------------------------------------------------------
// Ultrasonic ping ranger
// Each tick item is captured in the input register; its result is then registered in the output register.
// Throughput: one item per cycle while results are taken; a stalled result holds the input register.
// Synchronous active-low reset restores register defaults and holdoff phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ultrasonic_ping_ranger_assert.svh"

module ultrasonic_ping_ranger
  import upr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_echo_level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_drive_enable,
  output logic                  out_drive_level,
  output logic                  out_done_res,
  output logic [1:0]            out_status,
  output logic [15:0]           out_distance_mm,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [15:0] holdoff_r;
  logic [7:0]  trigger_r;
  logic [15:0] rise_to_r;
  logic [15:0] echo_max_r;
  logic [9:0]  mm_r;
  logic [15:0] limit_r;

  logic        in_valid_r;
  logic        in_level_r;
  logic        advance;

  phase_t      phase_r, phase_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic        last_r;
  logic [25:0] prod_r, prod_nxt;

  logic        out_valid_r;
  logic        en_r, lvl_r, done_r;
  logic [1:0]  status_r;
  logic [15:0] dist_r;

  logic        en_nxt, lvl_nxt, done_nxt;
  logic [1:0]  status_nxt;
  logic [15:0] dist_nxt;

  logic [16:0] n;
  logic [52:0] recip;
  logic [16:0] dist_q;
  logic [15:0] dist_sat;
  logic        rise;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holdoff_r  <= RST_HOLDOFF;
      trigger_r  <= RST_TRIGGER;
      rise_to_r  <= RST_RISE_TIMEOUT;
      echo_max_r <= RST_ECHO_MAX;
      mm_r       <= RST_MM_PER_MS;
      limit_r    <= RST_RANGE_LIMIT;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HOLDOFF:      holdoff_r  <= cfg_data;
        CFG_TRIGGER:      trigger_r  <= cfg_data[7:0];
        CFG_RISE_TIMEOUT: rise_to_r  <= cfg_data;
        CFG_ECHO_MAX:     echo_max_r <= cfg_data;
        CFG_MM_PER_MS:    mm_r       <= cfg_data[9:0];
        CFG_RANGE_LIMIT:  limit_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_level_r <= in_echo_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HOLDOFF;
      elapsed_r <= '0;
      last_r    <= 1'b0;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      last_r    <= in_level_r;
    end
  end

  // hold elapsed_r * mm_r; rebuild it when the scale is rewritten
  always_ff @(posedge clk) begin
    if (advance) begin
      prod_r <= prod_nxt;
    end else if (cfg_valid && cfg_index == CFG_MM_PER_MS) begin
      prod_r <= {10'd0, elapsed_r} * {16'd0, cfg_data[9:0]};
    end
  end

  assign n        = {1'b0, elapsed_r} + 17'd1;
  assign recip    = {27'd0, prod_r} * {26'd0, MM_RECIP};
  assign dist_q   = recip[MM_RECIP_SHIFT +: 17];
  assign dist_sat = dist_q[16] ? 16'hFFFF : dist_q[15:0];
  assign rise     = in_level_r && !last_r;

  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = n[15:0];
    prod_nxt    = prod_r;
    en_nxt      = 1'b0;
    lvl_nxt     = 1'b0;
    done_nxt    = 1'b0;
    status_nxt  = ST_OK;
    dist_nxt    = '0;
    case (phase_r)
      PH_HOLDOFF: begin
        if (n >= {1'b0, holdoff_r}) begin
          phase_nxt   = PH_TRIGGER;
          elapsed_nxt = '0;
        end
      end
      PH_TRIGGER: begin
        en_nxt  = 1'b1;
        lvl_nxt = 1'b1;
        if (n >= {9'd0, trigger_r}) begin
          phase_nxt   = PH_WAITRISE;
          elapsed_nxt = '0;
        end
      end
      PH_WAITRISE: begin
        if (rise) begin
          if (echo_max_r == 16'd0) begin
            done_nxt    = 1'b1;
            status_nxt  = ST_EPE;
            phase_nxt   = PH_HOLDOFF;
            elapsed_nxt = '0;
          end else begin
            phase_nxt   = PH_ECHO;
            elapsed_nxt = 16'd1;
            prod_nxt    = {16'd0, mm_r};
          end
        end else if (n >= {1'b0, rise_to_r}) begin
          done_nxt    = 1'b1;
          status_nxt  = ST_NORESP;
          phase_nxt   = PH_HOLDOFF;
          elapsed_nxt = '0;
        end
      end
      PH_ECHO: begin
        if (!in_level_r) begin
          done_nxt    = 1'b1;
          phase_nxt   = PH_HOLDOFF;
          elapsed_nxt = '0;
          if (dist_sat >= limit_r) begin
            status_nxt = ST_FAR;
          end else begin
            dist_nxt = dist_sat;
          end
        end else if (n > {1'b0, echo_max_r}) begin
          done_nxt    = 1'b1;
          status_nxt  = ST_EPE;
          phase_nxt   = PH_HOLDOFF;
          elapsed_nxt = '0;
        end else begin
          prod_nxt = prod_r + {16'd0, mm_r};
        end
      end
      default: begin
        phase_nxt   = PH_HOLDOFF;
        elapsed_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= advance || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      en_r     <= en_nxt;
      lvl_r    <= lvl_nxt;
      done_r   <= done_nxt;
      status_r <= status_nxt;
      dist_r   <= dist_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_drive_enable = en_r;
  assign out_drive_level  = lvl_r;
  assign out_done_res     = done_r;
  assign out_status       = status_r;
  assign out_distance_mm  = dist_r;

  `UPR_ASSERT_IMPLIES(a_idle_result_clear, clk, rst_n, out_valid_r && !done_r,
                      status_r == ST_OK && dist_r == 16'd0)
  `UPR_ASSERT_IMPLIES(a_trigger_no_done, clk, rst_n, out_valid_r && en_r,
                      lvl_r && !done_r)
  `UPR_ASSERT_NEXT(a_done_to_holdoff, clk, rst_n, advance && done_nxt,
                   phase_r == PH_HOLDOFF && elapsed_r == 16'd0)

endmodule

[verif/ultrasonic_ping_ranger_test.sv]
// ----------------------------------------------------------------------------
// Ultrasonic ping ranger testbench
// Sends echo tick items through several register settings and checks every
// result item, field by field, against a tick-level predictor of the ranging
// sequence: holdoff, trigger, wait for rise, echo timing and mm conversion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ultrasonic_ping_ranger_test;
  import upr_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int CYCLE_LIMIT = 2_500_000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum int {
    PING_ECHO,
    PING_TIMEOUT,
    PING_HELD,
    PING_NOISE
  } ping_kind_t;

  typedef struct packed {
    logic       drive_en;
    logic       drive_lvl;
    logic       done;
    logic [1:0] status;
    logic [15:0] dist_mm;
  } ranger_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_echo_level = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_drive_enable;
  logic                  out_drive_level;
  logic                  out_done_res;
  logic [1:0]            out_status;
  logic [15:0]           out_distance_mm;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ultrasonic_ping_ranger dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_echo_level    (in_echo_level),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_drive_enable (out_drive_enable),
    .out_drive_level  (out_drive_level),
    .out_done_res     (out_done_res),
    .out_status       (out_status),
    .out_distance_mm  (out_distance_mm),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  logic [15:0] hold_cfg  = RST_HOLDOFF;
  logic [7:0]  trig_cfg  = RST_TRIGGER;
  logic [15:0] rise_cfg  = RST_RISE_TIMEOUT;
  logic [15:0] echo_cfg  = RST_ECHO_MAX;
  logic [9:0]  mm_cfg    = RST_MM_PER_MS;
  logic [15:0] range_cfg = RST_RANGE_LIMIT;

  phase_t      phase_now   = PH_HOLDOFF;
  logic [15:0] elapsed_now = '0;
  logic        prev_level  = 1'b0;

  logic           echo_ticks[$];
  ranger_result_t expected_results[$];

  int  mismatches = 0;
  int  cycle_count = 0;
  int  in_gap = 0;
  int  out_gap = 0;
  bit  quiet = 1'b0;

  task automatic predict_ranger(input logic lvl);
    ranger_result_t r;
    int n;
    int mm;
    r = '0;
    n = int'(elapsed_now) + 1;
    case (phase_now)
      PH_HOLDOFF: begin
        if (n >= hold_cfg) begin
          phase_now = PH_TRIGGER;
          elapsed_now = '0;
        end else begin
          elapsed_now = n[15:0];
        end
      end
      PH_TRIGGER: begin
        r.drive_en = 1'b1;
        r.drive_lvl = 1'b1;
        if (n >= trig_cfg) begin
          phase_now = PH_WAITRISE;
          elapsed_now = '0;
        end else begin
          elapsed_now = n[15:0];
        end
      end
      PH_WAITRISE: begin
        if (lvl && !prev_level) begin
          if (echo_cfg == 16'd0) begin
            r.done = 1'b1;
            r.status = ST_EPE;
            phase_now = PH_HOLDOFF;
            elapsed_now = '0;
          end else begin
            phase_now = PH_ECHO;
            elapsed_now = 16'd1;
          end
        end else if (n >= rise_cfg) begin
          r.done = 1'b1;
          r.status = ST_NORESP;
          phase_now = PH_HOLDOFF;
          elapsed_now = '0;
        end else begin
          elapsed_now = n[15:0];
        end
      end
      default: begin
        if (!lvl) begin
          mm = (int'(elapsed_now) * int'(mm_cfg)) / int'(MM_DIV);
          if (mm > 65535) mm = 65535;
          r.done = 1'b1;
          if (mm >= range_cfg) begin
            r.status = ST_FAR;
          end else begin
            r.status = ST_OK;
            r.dist_mm = mm[15:0];
          end
          phase_now = PH_HOLDOFF;
          elapsed_now = '0;
        end else if (n > echo_cfg) begin
          r.done = 1'b1;
          r.status = ST_EPE;
          phase_now = PH_HOLDOFF;
          elapsed_now = '0;
        end else begin
          elapsed_now = n[15:0];
        end
      end
    endcase
    prev_level = lvl;
    expected_results.push_back(r);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ultrasonic_ping_ranger_test: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_ranger(echo_ticks[0]);
        void'(echo_ticks.pop_front());
      end else if (in_valid) begin
        // hold the item until accepted
      end
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0 && !quiet) begin
          in_gap = in_gap - 1;
          in_valid <= 1'b0;
        end else if (echo_ticks.size() > 0 && !quiet && $urandom_range(0, 19) == 0) begin
          in_gap = $urandom_range(1, 17) - 1;
          in_valid <= 1'b0;
        end else if (echo_ticks.size() > 0) begin
          in_valid <= 1'b1;
          in_echo_level <= echo_ticks[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    ranger_result_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result item with no expected result pending");
          mismatches++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_drive_enable !== exp_r.drive_en) begin
            $error("drive_enable: expected %0d, got %0d", exp_r.drive_en, out_drive_enable);
            mismatches++;
          end
          if (out_drive_level !== exp_r.drive_lvl) begin
            $error("drive_level: expected %0d, got %0d", exp_r.drive_lvl, out_drive_level);
            mismatches++;
          end
          if (out_done_res !== exp_r.done) begin
            $error("done_res: expected %0d, got %0d", exp_r.done, out_done_res);
            mismatches++;
          end
          if (out_status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_status);
            mismatches++;
          end
          if (out_distance_mm !== exp_r.dist_mm) begin
            $error("distance_mm: expected %0d, got %0d", exp_r.dist_mm, out_distance_mm);
            mismatches++;
          end
        end
      end
      if (out_gap > 0 && !quiet) begin
        out_gap = out_gap - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 19) == 0) begin
        out_gap = $urandom_range(1, 17) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic int ticks_left(int spent, int span);
    return (spent + 1 >= span) ? 1 : span - spent;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
    case (idx)
      CFG_HOLDOFF:      hold_cfg = val;
      CFG_TRIGGER:      trig_cfg = val[7:0];
      CFG_RISE_TIMEOUT: rise_cfg = val;
      CFG_ECHO_MAX:     echo_cfg = val;
      CFG_MM_PER_MS:    mm_cfg = val[9:0];
      CFG_RANGE_LIMIT:  range_cfg = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [15:0] h, input logic [7:0] t,
                               input logic [15:0] rt, input logic [15:0] em,
                               input logic [9:0] mpm, input logic [15:0] rl);
    logic [15:0] pad;
    @(negedge clk);
    while (echo_ticks.size() != 0 || expected_results.size() != 0 || in_valid) @(negedge clk);
    repeat (4) @(negedge clk);
    pad = 16'($urandom);
    write_reg(CFG_HOLDOFF, h);
    write_reg(CFG_TRIGGER, {pad[7:0], t});
    write_reg(CFG_RISE_TIMEOUT, rt);
    write_reg(CFG_ECHO_MAX, em);
    write_reg(CFG_MM_PER_MS, {pad[15:10], mpm});
    write_reg(CFG_RANGE_LIMIT, rl);
    write_reg(pad[0] ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom));
  endtask

  // queue one ranging sequence aligned to the predicted phase, or random noise ticks
  task automatic queue_ping(input ping_kind_t kind, input int width, input int delay);
    int lead;
    int rt_eff;
    int d;
    int w;
    @(negedge clk);
    while (echo_ticks.size() != 0) @(negedge clk);
    if (kind == PING_NOISE || phase_now == PH_WAITRISE || phase_now == PH_ECHO) begin
      repeat ($urandom_range(1, 12)) echo_ticks.push_back(1'($urandom_range(0, 1)));
    end else begin
      if (phase_now == PH_HOLDOFF)
        lead = ticks_left(elapsed_now, hold_cfg) + ticks_left(0, trig_cfg);
      else
        lead = ticks_left(elapsed_now, trig_cfg);
      repeat (lead - 1) echo_ticks.push_back(1'($urandom_range(0, 1)));
      echo_ticks.push_back(kind == PING_HELD);
      rt_eff = (rise_cfg == 16'd0) ? 1 : int'(rise_cfg);
      case (kind)
        PING_TIMEOUT: repeat (rt_eff) echo_ticks.push_back(1'b0);
        PING_HELD:    repeat (rt_eff) echo_ticks.push_back(1'b1);
        default: begin
          d = (delay > rt_eff - 1) ? rt_eff - 1 : delay;
          w = (width < 1) ? 1 : width;
          if (w > int'(echo_cfg) + 1) w = int'(echo_cfg) + 1;
          repeat (d) echo_ticks.push_back(1'b0);
          repeat (w) echo_ticks.push_back(1'b1);
          if (w <= int'(echo_cfg)) echo_ticks.push_back(1'b0);
        end
      endcase
    end
  endtask

  task automatic random_pings(input int min_items, input int min_pings);
    int items;
    int pings;
    int pick;
    int wid;
    int dly;
    items = 0;
    pings = 0;
    while (items < min_items || pings < min_pings) begin
      if (pings % 8 == 0)
        load_settings(16'($urandom_range(0, 6)), 8'($urandom_range(1, 4)),
                      16'($urandom_range(0, 12)), 16'($urandom_range(0, 24)),
                      10'($urandom_range(0, 1023)),
                      ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                  : 16'($urandom_range(0, 30)));
      pick = $urandom_range(0, 99);
      wid = (echo_cfg == 16'd0) ? 1 : $urandom_range(1, echo_cfg);
      dly = $urandom_range(0, rise_cfg);
      if (pick < 68)      queue_ping(PING_ECHO, wid, dly);
      else if (pick < 78) queue_ping(PING_ECHO, int'(echo_cfg) + 1, dly);
      else if (pick < 86) queue_ping(PING_TIMEOUT, 0, 0);
      else if (pick < 92) queue_ping(PING_HELD, 0, 0);
      else                queue_ping(PING_NOISE, 0, 0);
      items += echo_ticks.size();
      pings++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values
    queue_ping(PING_ECHO, 20, 2);

    // shortest phases, zero echo limit
    load_settings(16'd0, 8'd1, 16'd0, 16'd0, 10'd1023, 16'd65535);
    queue_ping(PING_TIMEOUT, 0, 0);
    queue_ping(PING_ECHO, 1, 0);
    queue_ping(PING_HELD, 0, 0);
    queue_ping(PING_NOISE, 0, 0);

    // distance just below and at the limit, rise on the timeout tick
    load_settings(16'd3, 8'd2, 16'd4, 16'd3, 10'd1000, 16'd2);
    queue_ping(PING_ECHO, 1, 0);
    queue_ping(PING_ECHO, 2, 3);
    queue_ping(PING_ECHO, 3, 1);
    queue_ping(PING_ECHO, 4, 0);
    queue_ping(PING_HELD, 0, 0);
    queue_ping(PING_TIMEOUT, 0, 0);

    // zero scale and zero limit
    load_settings(16'd1, 8'd2, 16'd2, 16'd10, 10'd0, 16'd0);
    queue_ping(PING_ECHO, 5, 1);
    queue_ping(PING_ECHO, 10, 0);

    random_pings(300, 20);

    quiet = 1'b1;
    random_pings(100, 8);

    @(negedge clk);
    while (echo_ticks.size() != 0 || expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("ultrasonic_ping_ranger_test: done, clean");
    end else begin
      $display("ultrasonic_ping_ranger_test: done, errors");
    end
    $finish;
  end

endmodule
